// ===== src/iolhm_pkg.sv =====
// Package for the I/O latency histogram monitor: sizes, codes, states and
// the histogram bucket limits. No dependencies.
`default_nettype none

package iolhm_pkg;

  // Store sizes
  localparam int Tags       = 256;
  localparam int TagW       = $clog2(Tags);
  localparam int Devices    = 16;
  localparam int DevW       = (Devices > 1) ? $clog2(Devices) : 1;
  localparam int PerDev     = 48;
  localparam int StatsDepth = Devices * PerDev;
  localparam int StatsAw    = $clog2(StatsDepth);
  localparam int Buckets    = 20;

  // Counter offsets inside one device's block
  localparam logic [5:0] OfsCount = 6'd0;
  localparam logic [5:0] OfsBytes = 6'd2;
  localparam logic [5:0] OfsLat   = 6'd4;
  localparam logic [5:0] OfsHist  = 6'd6;
  localparam logic [5:0] OfsErr   = 6'd46;

  // Request operation codes
  localparam logic [7:0] OpcRead  = 8'd0;
  localparam logic [7:0] OpcWrite = 8'd1;

  // Item operations
  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpDone  = 2'd1,
    OpRead  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StIgnored = 3'd1,
    StNoStart = 3'd2,
    StFull    = 3'd3,
    StUnknown = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SDoneLook,
    SDoneFind,
    SDoneUpd,
    SReadFind,
    SReadData,
    SFin
  } state_e;

  // One in-flight request
  typedef struct packed {
    logic [63:0] start;
    logic [19:0] dev;
    logic [31:0] len;
    logic        wr;
  } ifl_t;

  // Lower bucket edges in nanoseconds (microsecond limits times 1000)
  function automatic logic [22:0] bucket_edge_ns(input logic [4:0] i);
    logic [22:0] r;
    case (i)
      5'd0:  r = 23'd10000;
      5'd1:  r = 23'd14000;
      5'd2:  r = 23'd21000;
      5'd3:  r = 23'd30000;
      5'd4:  r = 23'd43000;
      5'd5:  r = 23'd62000;
      5'd6:  r = 23'd89000;
      5'd7:  r = 23'd127000;
      5'd8:  r = 23'd183000;
      5'd9:  r = 23'd264000;
      5'd10: r = 23'd379000;
      5'd11: r = 23'd546000;
      5'd12: r = 23'd785000;
      5'd13: r = 23'd1129000;
      5'd14: r = 23'd1624000;
      5'd15: r = 23'd2336000;
      5'd16: r = 23'd3360000;
      5'd17: r = 23'd4833000;
      5'd18: r = 23'd6952000;
      default: r = '1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/io_latency_histogram_monitor_top.sv =====
// Channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------------
// input     | in_valid_i / in_stall_o   | operation .. counter_index
// output    | out_valid_o / out_stall_i | status, req_lat_ns, bucket, read_value
//
// A done request with a match updates its device's counters, and the error counter
// as well when it reports an error (one counter read-modify-write per cycle on the
// single stats RAM); without a matching start, or when a new device finds the table
// full, it updates none.
// After reset a clearing pass zeroes the 768-entry stats RAM with in_stall_o high.
// A stalled result stays in the output register while the next request is accepted;
// the sequencer then waits in its last state.
// Depends on iolhm_pkg.
`default_nettype none

module io_latency_histogram_monitor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  request_tag_i,
  input  wire logic [19:0] dev_num_i,
  input  wire logic [7:0]  op_code_i,
  input  wire logic [31:0] data_length_i,
  input  wire logic [7:0]  error_status_i,
  input  wire logic [63:0] timestamp_ns_i,
  input  wire logic [5:0]  counter_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [63:0]      req_lat_ns_o,
  output logic [4:0]       bucket_o,
  output logic [63:0]      read_value_o
);
  import iolhm_pkg::*;

  localparam logic [2:0] StepCount = 3'd0;
  localparam logic [2:0] StepBytes = 3'd1;
  localparam logic [2:0] StepLat   = 3'd2;
  localparam logic [2:0] StepHist  = 3'd3;
  localparam logic [2:0] StepErr   = 3'd4;

  state_e state_q, state_d;
  logic [StatsAw-1:0] clr_q, clr_d;
  logic [2:0] step_q, step_d;
  logic [TagW-1:0] tag_q, tag_d;
  logic [19:0] dev_q, dev_d;
  logic [5:0] idx_q, idx_d;
  logic [63:0] ts_q, ts_d;
  logic err_q, err_d;
  logic [19:0] ent_dev_q, ent_dev_d;
  logic [31:0] ent_len_q, ent_len_d;
  logic ent_wr_q, ent_wr_d;
  logic [63:0] lat_q, lat_d;
  logic [DevW-1:0] slot_q, slot_d;
  logic [2:0] res_status_q, res_status_d;
  logic [63:0] res_lat_q, res_lat_d;
  logic [4:0] res_bucket_q, res_bucket_d;
  logic [63:0] res_value_q, res_value_d;
  logic out_valid_q, out_valid_d;
  logic [2:0] out_status_q, out_status_d;
  logic [63:0] out_lat_q, out_lat_d;
  logic [4:0] out_bucket_q, out_bucket_d;
  logic [63:0] out_value_q, out_value_d;
  logic [Tags-1:0] ifl_valid_q, ifl_valid_d;
  logic [Devices-1:0] dev_valid_q, dev_valid_d;
  logic [19:0] dev_key_q [Devices];
  logic dev_key_we;

  // Memories
  ifl_t ifl_mem [Tags];
  ifl_t ifl_rdata_q;
  ifl_t ifl_wdata;
  logic ifl_we;
  logic [63:0] st_mem [StatsDepth];
  logic [63:0] st_rdata_q;
  logic st_we;
  logic [StatsAw-1:0] st_waddr, st_raddr;
  logic [63:0] st_wdata;

  // Device search and bucket selection
  logic [19:0] key_sel;
  logic hit_any, free_any;
  logic [DevW-1:0] hit_slot, free_slot;
  logic [4:0] bkt;
  logic lat_hi;
  logic [2:0] nsteps;
  logic [StatsAw-1:0] slot_base;
  logic [StatsAw-1:0] prev_addr, cur_addr;
  logic [63:0] prev_inc;
  logic in_acc, out_free;

  // Offset of a counter touched by a done request
  function automatic logic [5:0] upd_ofs(input logic [2:0] s, input logic wr,
                                         input logic [4:0] b);
    logic [5:0] w;
    logic [5:0] r;
    w = {5'd0, wr};
    case (s)
      StepCount: r = OfsCount + w;
      StepBytes: r = OfsBytes + w;
      StepLat:   r = OfsLat + w;
      StepHist:  r = OfsHist + (wr ? 6'(Buckets) : 6'd0) + {1'b0, b};
      StepErr:   r = OfsErr + w;
      default:   r = OfsCount;
    endcase
    return r;
  endfunction

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Search the device table
  always_comb begin
    key_sel   = (state_q == SReadFind) ? dev_q : ent_dev_q;
    hit_any   = 1'b0;
    free_any  = 1'b0;
    hit_slot  = '0;
    free_slot = '0;
    for (int i = Devices - 1; i >= 0; i--) begin
      if (dev_valid_q[i] && dev_key_q[i] == key_sel) begin
        hit_any  = 1'b1;
        hit_slot = DevW'(i);
      end
      if (!dev_valid_q[i]) begin
        free_any  = 1'b1;
        free_slot = DevW'(i);
      end
    end
  end

  // Pick the histogram bucket from the registered latency
  always_comb begin
    lat_hi = |lat_q[63:23];
    bkt    = '0;
    for (int i = 0; i < Buckets - 1; i++) begin
      if (lat_hi || lat_q[22:0] >= bucket_edge_ns(5'(i))) begin
        bkt = 5'(i + 1);
      end
    end
  end

  // Counter addresses for the update walk
  always_comb begin
    slot_base = StatsAw'(slot_q) * StatsAw'(PerDev);
    nsteps    = err_q ? 3'd5 : 3'd4;
    cur_addr  = slot_base + StatsAw'(upd_ofs(step_q, ent_wr_q, res_bucket_q));
    prev_addr = slot_base + StatsAw'(upd_ofs(step_q - 3'd1, ent_wr_q, res_bucket_q));
    case (step_q - 3'd1)
      StepBytes: prev_inc = {32'd0, ent_len_q};
      StepLat:   prev_inc = lat_q;
      default:   prev_inc = 64'd1;
    endcase
  end

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    step_d       = step_q;
    tag_d        = tag_q;
    dev_d        = dev_q;
    idx_d        = idx_q;
    ts_d         = ts_q;
    err_d        = err_q;
    ent_dev_d    = ent_dev_q;
    ent_len_d    = ent_len_q;
    ent_wr_d     = ent_wr_q;
    lat_d        = lat_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_lat_d    = res_lat_q;
    res_bucket_d = res_bucket_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_lat_d    = out_lat_q;
    out_bucket_d = out_bucket_q;
    out_value_d  = out_value_q;
    ifl_valid_d  = ifl_valid_q;
    dev_valid_d  = dev_valid_q;
    dev_key_we   = 1'b0;
    ifl_we       = 1'b0;
    ifl_wdata    = '{start: timestamp_ns_i, dev: dev_num_i, len: data_length_i,
                     wr: (op_code_i == OpcWrite)};
    st_we        = 1'b0;
    st_waddr     = prev_addr;
    st_wdata     = st_rdata_q + prev_inc;
    st_raddr     = cur_addr;
    in_stall_o   = (state_q != SIdle);

    case (state_q)
      // Zero the stats RAM after reset
      SClear: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == StatsAw'(StatsDepth - 1)) begin
          state_d = SIdle;
        end
      end
      // Take a request
      SIdle: begin
        if (in_acc) begin
          tag_d        = request_tag_i[TagW-1:0];
          dev_d        = dev_num_i;
          idx_d        = counter_index_i;
          ts_d         = timestamp_ns_i;
          err_d        = |error_status_i;
          res_status_d = StIgnored;
          res_lat_d    = '0;
          res_bucket_d = '0;
          res_value_d  = '0;
          state_d      = SFin;
          case (operation_i)
            OpStart: begin
              if (dev_num_i != '0 && (op_code_i == OpcRead || op_code_i == OpcWrite)) begin
                ifl_we = 1'b1;
                ifl_valid_d[request_tag_i[TagW-1:0]] = 1'b1;
                res_status_d = StOk;
              end
            end
            OpDone: state_d = SDoneLook;
            OpRead: begin
              if (counter_index_i < 6'(PerDev)) begin
                state_d = SReadFind;
              end
            end
            default: state_d = SFin;
          endcase
        end
      end
      // Check the tag and measure latency
      SDoneLook: begin
        if (!ifl_valid_q[tag_q]) begin
          res_status_d = StNoStart;
          state_d      = SFin;
        end else begin
          lat_d     = ts_q - ifl_rdata_q.start;
          ent_dev_d = ifl_rdata_q.dev;
          ent_len_d = ifl_rdata_q.len;
          ent_wr_d  = ifl_rdata_q.wr;
          state_d   = SDoneFind;
        end
      end
      // Find or insert the device, free the tag
      SDoneFind: begin
        ifl_valid_d[tag_q] = 1'b0;
        res_lat_d    = lat_q;
        res_bucket_d = bkt;
        step_d       = '0;
        res_status_d = StOk;
        state_d      = SDoneUpd;
        if (hit_any) begin
          slot_d = hit_slot;
        end else if (free_any) begin
          slot_d = free_slot;
          dev_valid_d[free_slot] = 1'b1;
          dev_key_we = 1'b1;
        end else begin
          res_status_d = StFull;
          state_d      = SFin;
        end
      end
      // Read one counter, write back the previous one
      SDoneUpd: begin
        st_we = (step_q != 3'd0);
        if (step_q == nsteps) begin
          state_d = SFin;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      // Look up the device for a counter read
      SReadFind: begin
        if (!hit_any) begin
          res_status_d = StUnknown;
          state_d      = SFin;
        end else begin
          st_raddr     = StatsAw'(hit_slot) * StatsAw'(PerDev) + StatsAw'(idx_q);
          res_status_d = StOk;
          state_d      = SReadData;
        end
      end
      SReadData: begin
        res_value_d = st_rdata_q;
        state_d     = SFin;
      end
      // Hand the result to the output register
      SFin: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_lat_d    = res_lat_q;
          out_bucket_d = res_bucket_q;
          out_value_d  = res_value_q;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      ifl_valid_q <= '0;
      dev_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      ifl_valid_q <= ifl_valid_d;
      dev_valid_q <= dev_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tag_q        <= tag_d;
    dev_q        <= dev_d;
    idx_q        <= idx_d;
    ts_q         <= ts_d;
    err_q        <= err_d;
    ent_dev_q    <= ent_dev_d;
    ent_len_q    <= ent_len_d;
    ent_wr_q     <= ent_wr_d;
    lat_q        <= lat_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_lat_q    <= res_lat_d;
    res_bucket_q <= res_bucket_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_lat_q    <= out_lat_d;
    out_bucket_q <= out_bucket_d;
    out_value_q  <= out_value_d;
    if (dev_key_we) begin
      dev_key_q[free_slot] <= ent_dev_q;
    end
  end

  // In-flight store
  always_ff @(posedge clk_i) begin
    if (ifl_we) begin
      ifl_mem[request_tag_i[TagW-1:0]] <= ifl_wdata;
    end
    ifl_rdata_q <= ifl_mem[request_tag_i[TagW-1:0]];
  end

  // Device counter store
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata_q <= st_mem[st_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign req_lat_ns_o = out_lat_q;
  assign bucket_o     = out_bucket_q;
  assign read_value_o = out_value_q;

  // Checks
  a_dev_table_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(dev_valid_q) >= $past($countones(dev_valid_q)))
    else $error("device table lost an entry");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDoneUpd) |-> (res_bucket_q < 5'(Buckets)))
    else $error("bucket out of range");

  a_rmw_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDoneUpd && st_we && step_q != nsteps) |-> (st_waddr != st_raddr))
    else $error("counter read and write collide");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == SFin))
    else $error("result raised outside the final state");

endmodule

`default_nettype wire

// ===== verif/tb_io_latency_histogram_monitor_top.sv =====
// Self-checking testbench for io_latency_histogram_monitor_top: directed and random
// start/done/read requests, an internal latency histogram predictor, a result scoreboard.
// Depends on iolhm_pkg and the top-level RTL.
`default_nettype none

module tb_io_latency_histogram_monitor_top;
  timeunit 1ns;
  timeprecision 1ps;
  import iolhm_pkg::*;

  typedef struct {
    logic [1:0]  operation;
    logic [7:0]  request_tag;
    logic [19:0] dev_num;
    logic [7:0]  op_code;
    logic [31:0] data_length;
    logic [7:0]  error_status;
    logic [63:0] timestamp_ns;
    logic [5:0]  counter_index;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] req_lat_ns;
    logic [4:0]  bucket;
    logic [63:0] read_value;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [7:0]  request_tag_i = '0;
  logic [19:0] dev_num_i = '0;
  logic [7:0]  op_code_i = '0;
  logic [31:0] data_length_i = '0;
  logic [7:0]  error_status_i = '0;
  logic [63:0] timestamp_ns_i = '0;
  logic [5:0]  counter_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] req_lat_ns_o;
  logic [4:0]  bucket_o;
  logic [63:0] read_value_o;

  io_latency_histogram_monitor_top u_dut (.*);

  // Predictor state
  logic        tag_busy [Tags];
  logic [63:0] tag_start [Tags];
  logic [19:0] tag_dev [Tags];
  logic [31:0] tag_len [Tags];
  logic        tag_wr [Tags];
  logic        dev_used [Devices];
  logic [19:0] dev_key [Devices];
  logic [63:0] dev_ctr [Devices][PerDev];

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int  errors = 0;
  int  accepted = 0;
  int  checked = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;
  logic [63:0] clock_ns = 64'd5000;
  logic [19:0] dev_pool [24];

  localparam int unsigned LimitNs [19] = '{10000, 14000, 21000, 30000, 43000, 62000,
    89000, 127000, 183000, 264000, 379000, 546000, 785000, 1129000, 1624000, 2336000,
    3360000, 4833000, 6952000};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [4:0] latency_bucket(logic [63:0] lat);
    logic [63:0] us;
    int b;
    us = lat / 64'd1000;
    b = 0;
    while (b < Buckets - 1 && us * 1000 >= LimitNs[b]) b++;
    return 5'(b);
  endfunction

  function automatic int lookup_device(logic [19:0] dev);
    for (int i = 0; i < Devices; i++)
      if (dev_used[i] && dev_key[i] == dev) return i;
    return -1;
  endfunction

  // Advance the predictor by one request and return its outcome
  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    int slot;
    int w;
    o = '{StIgnored, 64'd0, 5'd0, 64'd0};
    case (r.operation)
      OpStart: if (r.dev_num != 0 && r.op_code <= OpcWrite) begin
        tag_busy[r.request_tag] = 1'b1;
        tag_start[r.request_tag] = r.timestamp_ns;
        tag_dev[r.request_tag] = r.dev_num;
        tag_len[r.request_tag] = r.data_length;
        tag_wr[r.request_tag] = (r.op_code == OpcWrite);
        o.status = StOk;
      end
      OpDone: if (!tag_busy[r.request_tag]) begin
        o.status = StNoStart;
      end else begin
        slot = lookup_device(tag_dev[r.request_tag]);
        o.req_lat_ns = r.timestamp_ns - tag_start[r.request_tag];
        o.bucket = latency_bucket(o.req_lat_ns);
        if (slot < 0) begin
          for (int i = 0; i < Devices; i++) begin
            if (!dev_used[i]) begin
              slot = i;
              dev_used[i] = 1'b1;
              dev_key[i] = tag_dev[r.request_tag];
              for (int k = 0; k < PerDev; k++) dev_ctr[i][k] = '0;
              break;
            end
          end
        end
        if (slot < 0) begin
          o.status = StFull;
        end else begin
          w = tag_wr[r.request_tag];
          dev_ctr[slot][OfsCount + w] += 1;
          dev_ctr[slot][OfsBytes + w] += 64'(tag_len[r.request_tag]);
          dev_ctr[slot][OfsLat + w] += o.req_lat_ns;
          dev_ctr[slot][OfsHist + w * Buckets + o.bucket] += 1;
          if (r.error_status != 0) dev_ctr[slot][OfsErr + w] += 1;
          o.status = StOk;
        end
        tag_busy[r.request_tag] = 1'b0;
      end
      OpRead: if (r.counter_index < PerDev) begin
        slot = lookup_device(r.dev_num);
        if (slot < 0) o.status = StUnknown;
        else begin
          o.read_value = dev_ctr[slot][r.counter_index];
          o.status = StOk;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic request_t make_request(logic [1:0] op, logic [7:0] tag,
      logic [19:0] dev, logic [7:0] opc, logic [31:0] len, logic [7:0] st,
      logic [63:0] ts, logic [5:0] idx);
    request_t r;
    r = '{op, tag, dev, opc, len, st, ts, idx};
    return r;
  endfunction

  task automatic add_request(request_t r);
    pending_requests.push_back(r);
  endtask

  // Driver: bursts with random gaps, hold payload while stalled
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk_i) begin
    request_t r;
    if (rst_ni) begin
      if (!(in_valid_i && in_stall_o)) begin
        if (in_valid_i) begin
          expected_outcomes.push_back(predict_outcome(pending_requests.pop_front()));
          accepted <= accepted + 1;
        end
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          r = pending_requests[0];
          in_valid_i <= 1'b1;
          operation_i <= r.operation;
          request_tag_i <= r.request_tag;
          dev_num_i <= r.dev_num;
          op_code_i <= r.op_code;
          data_length_i <= r.data_length;
          error_status_i <= r.error_status;
          timestamp_ns_i <= r.timestamp_ns;
          counter_index_i <= r.counter_index;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: phases of steady flow, light stalling and heavy stalling
  int stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 150) out_stall_i <= 1'b0;
    else if (stall_phase < 300) out_stall_i <= ($urandom_range(0, 3) == 0);
    else out_stall_i <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked <= checked + 1;
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: status %0d", status_o);
        errors++;
      end else begin
        e = expected_outcomes.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status_o);
          errors++;
        end
        if (req_lat_ns_o !== e.req_lat_ns) begin
          $error("req_lat_ns: expected %0d actual %0d", e.req_lat_ns, req_lat_ns_o);
          errors++;
        end
        if (bucket_o !== e.bucket) begin
          $error("bucket: expected %0d actual %0d", e.bucket, bucket_o);
          errors++;
        end
        if (read_value_o !== e.read_value) begin
          $error("read_value: expected %0d actual %0d", e.read_value, read_value_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("io_latency_histogram_monitor_top regression: fail");
      $finish;
    end
  end

  function automatic logic [19:0] rand_dev();
    return dev_pool[$urandom_range(0, 23)];
  endfunction

  initial begin
    int kind;
    logic [63:0] lat;
    logic [7:0] tag;
    for (int i = 0; i < Tags; i++) begin
      tag_busy[i] = 0; tag_start[i] = '0; tag_dev[i] = '0; tag_len[i] = '0; tag_wr[i] = 0;
    end
    for (int i = 0; i < Devices; i++) begin
      dev_used[i] = 0; dev_key[i] = '0;
      for (int k = 0; k < PerDev; k++) dev_ctr[i][k] = '0;
    end
    dev_pool[0] = 20'hFFFFF;
    dev_pool[1] = 20'h00801;
    for (int i = 2; i < 24; i++) dev_pool[i] = 20'($urandom_range(1, 20'hFFFFF));

    // Directed: extremes, every operation, special cases
    add_request(make_request(OpRead, 0, 20'h00801, 0, 0, 0, 0, 0));        // unknown device
    add_request(make_request(OpDone, 8'd7, 0, 0, 0, 0, 0, 0));             // done without start
    add_request(make_request(OpStart, 8'd1, 20'd0, OpcRead, 1, 0, 0, 0));  // device zero
    add_request(make_request(OpStart, 8'd1, 20'd5, 8'hFF, 1, 0, 0, 0));    // bad op code
    add_request(make_request(OpStart, 8'd255, 20'hFFFFF, OpcWrite, 32'hFFFFFFFF, 0,
                             64'hFFFFFFFFFFFFFF00, 0));
    add_request(make_request(OpDone, 8'd255, 0, 0, 0, 8'hFF, 64'h0000000000001000, 0));
    add_request(make_request(OpStart, 8'd0, 20'h00801, OpcRead, 0, 0, 64'd100, 0));
    add_request(make_request(OpStart, 8'd0, 20'h00801, OpcRead, 512, 0, 64'd200, 0));
    add_request(make_request(OpDone, 8'd0, 20'hFFFFF, 8'hFF, 0, 0, 64'd10199, 0));
    add_request(make_request(OpStart, 8'd2, 20'h00801, OpcRead, 4096, 0, 64'd0, 0));
    add_request(make_request(OpDone, 8'd2, 0, 0, 0, 8'd1, 64'hFFFFFFFFFFFFFFFF, 0));
    for (int k = 0; k < 48; k += 4)
      add_request(make_request(OpRead, 0, 20'h00801, 0, 0, 0, 0, 6'(k + 2)));
    add_request(make_request(OpRead, 0, 20'hFFFFF, 0, 0, 0, 0, 6'd47));
    add_request(make_request(OpRead, 0, 20'hFFFFF, 0, 0, 0, 0, 6'd63));    // index past end
    add_request(make_request(2'd3, 8'hAA, 20'h55555, 8'h55, 32'hAAAAAAAA, 8'hAA,
                             64'h5555555555555555, 6'h2A));                // unused op

    // Random: mostly matched start/done pairs across the 20 buckets
    for (int n = 0; n < 1820; n++) begin
      kind = $urandom_range(0, 99);
      tag = 8'($urandom_range(0, 255));
      clock_ns += 64'($urandom_range(0, 50000));
      if (n == 900) for (int i = 2; i < 24; i++) dev_pool[i] = 20'($urandom);
      if (kind < 40) begin
        add_request(make_request(OpStart, tag, rand_dev(), 8'($urandom_range(0, 1)),
                                 $urandom, 0, clock_ns, 0));
      end else if (kind < 75) begin
        case ($urandom_range(0, 3))
          0: lat = 64'($urandom_range(0, 20000));
          1: lat = 64'($urandom_range(0, 8000000));
          2: lat = LimitNs[$urandom_range(0, 18)] - 64'($urandom_range(0, 1));
          default: lat = {$urandom, $urandom};
        endcase
        add_request(make_request(OpDone, tag, 20'($urandom), 8'($urandom), $urandom,
                                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 0,
                                 tag_start[tag] + lat, 6'($urandom)));
        // keep predictor's start snapshot meaningful only; tag reuse handled at acceptance
      end else if (kind < 95) begin
        add_request(make_request(OpRead, tag, rand_dev(), 8'($urandom), $urandom, 8'($urandom),
                                 {$urandom, $urandom}, 6'($urandom_range(0, 47))));
      end else begin
        add_request(make_request(2'($urandom), tag, 20'($urandom), 8'($urandom), $urandom,
                                 8'($urandom), {$urandom, $urandom}, 6'($urandom)));
      end
      // Stamp starts ahead of acceptance so done latencies stay meaningful
      if (pending_requests[$].operation == OpStart) tag_start[tag] = clock_ns;
    end
    // Restore predictor state; stamps above were planning only
    for (int i = 0; i < Tags; i++) tag_start[i] = '0;
    begin
      int unsigned total;
      total = pending_requests.size();
      repeat (9) @(posedge clk_i);
      rst_ni <= 1'b1;
      wait (pending_requests.size() == 0 && !in_valid_i);
      wait (expected_outcomes.size() == 0);
      repeat (40) @(posedge clk_i);
      $display("Covered %0d requests (start, done, read, unused op) with %0d results checked",
               total, checked);
      $display("across 24 device ids, all 20 latency buckets and table overflow.");
      if (errors == 0 && expected_outcomes.size() == 0)
        $display("io_latency_histogram_monitor_top regression: pass");
      else
        $display("io_latency_histogram_monitor_top regression: fail");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/iolhm_pkg.sv
src/io_latency_histogram_monitor_top.sv
verif/tb_io_latency_histogram_monitor_top.sv
